### src/ppc_pkg.sv
package ppc_pkg;

  // default datapath format
  localparam int unsigned DATA_WIDTH = 32;
  localparam int unsigned FRAC_BITS  = 16;

  // configuration port
  localparam int unsigned TOL_W      = 16;
  localparam int unsigned APB_ADDR_W = 3;
  localparam int unsigned APB_DATA_W = 32;

  // register index, taken from paddr[2]
  localparam logic [0:0] RegZeroTol = 1'b0;

  // control flags that ride along with every item
  typedef struct packed {
    logic valid;
    logic neg;
    logic degen;
    logic sat;
  } ppc_flags_t;

endpackage

### src/ppc_if.sv
// input channel: derivatives of one curve point
interface ppc_in_if import ppc_pkg::*; #(
  parameter int unsigned DW = DATA_WIDTH
) ();
  logic          valid;
  logic          ready;
  logic signed [DW-1:0] first_deriv_x;
  logic signed [DW-1:0] second_deriv_x;
  logic signed [DW-1:0] first_deriv_y;
  logic signed [DW-1:0] second_deriv_y;

  modport source (
    output valid, first_deriv_x, second_deriv_x, first_deriv_y, second_deriv_y,
    input  ready
  );
  modport sink (
    input  valid, first_deriv_x, second_deriv_x, first_deriv_y, second_deriv_y,
    output ready
  );
endinterface

// output channel: curvature and status
interface ppc_out_if import ppc_pkg::*; #(
  parameter int unsigned DW = DATA_WIDTH
) ();
  logic          valid;
  logic          ready;
  logic signed [DW-1:0] curvature;
  logic          degenerate;
  logic          saturated;

  modport source (
    output valid, curvature, degenerate, saturated,
    input  ready
  );
  modport sink (
    input  valid, curvature, degenerate, saturated,
    output ready
  );
endinterface

### src/ppc_sqrt_cell.sv
module ppc_sqrt_cell import ppc_pkg::*; #(
  parameter int unsigned W      = DATA_WIDTH,
  parameter int unsigned SIDE_W = 4 * DATA_WIDTH
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  ppc_flags_t        flags_i,
  input  logic [W+1:0]      rem_i,
  input  logic [W-1:0]      root_i,
  input  logic [2*W-1:0]    n_i,
  input  logic [SIDE_W-1:0] side_i,
  output ppc_flags_t        flags_o,
  output logic [W+1:0]      rem_o,
  output logic [W-1:0]      root_o,
  output logic [2*W-1:0]    n_o,
  output logic [SIDE_W-1:0] side_o
);

  ppc_flags_t        flags_q;
  logic [W+1:0]      rem_q, rem_d;
  logic [W-1:0]      root_q, root_d;
  logic [2*W-1:0]    n_q;
  logic [SIDE_W-1:0] side_q;

  logic [W+3:0] shifted;
  logic [W+3:0] trial;
  logic [W+4:0] diff;
  logic         take;

  // one root digit: bring down two bits, try root*4+1
  always_comb begin
    shifted = {rem_i, n_i[2*W-1 -: 2]};
    trial   = {2'b00, root_i, 2'b01};
    diff    = {1'b0, shifted} - {1'b0, trial};
    take    = ~diff[W+4];
    rem_d   = take ? diff[W+1:0] : shifted[W+1:0];
    root_d  = {root_i[W-2:0], take};
  end

  // control flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      flags_q <= '0;
    end else if (en_i) begin
      flags_q <= flags_i;
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q  <= rem_d;
      root_q <= root_d;
      n_q    <= {n_i[2*W-3:0], 2'b00};
      side_q <= side_i;
    end
  end

  assign flags_o = flags_q;
  assign rem_o   = rem_q;
  assign root_o  = root_q;
  assign n_o     = n_q;
  assign side_o  = side_q;

endmodule

### src/ppc_div_cell.sv
module ppc_div_cell import ppc_pkg::*; #(
  parameter int unsigned W = DATA_WIDTH
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           en_i,
  input  ppc_flags_t     flags_i,
  input  logic [3*W-1:0] rem_i,
  input  logic [3*W-1:0] den_i,
  input  logic [W-1:0]   nb_i,
  input  logic [W-1:0]   q_i,
  output ppc_flags_t     flags_o,
  output logic [3*W-1:0] rem_o,
  output logic [3*W-1:0] den_o,
  output logic [W-1:0]   nb_o,
  output logic [W-1:0]   q_o
);

  ppc_flags_t     flags_q;
  logic [3*W-1:0] rem_q, rem_d;
  logic [3*W-1:0] den_q;
  logic [W-1:0]   nb_q;
  logic [W-1:0]   q_q;

  logic [3*W:0]   shifted;
  logic [3*W+1:0] diff;
  logic           take;

  // one restoring step: shift in next dividend bit, subtract if it fits
  always_comb begin
    shifted = {rem_i, nb_i[W-1]};
    diff    = {1'b0, shifted} - {2'b00, den_i};
    take    = ~diff[3*W+1];
    rem_d   = take ? diff[3*W-1:0] : shifted[3*W-1:0];
  end

  // control flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      flags_q <= '0;
    end else if (en_i) begin
      flags_q <= flags_i;
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q <= rem_d;
      den_q <= den_i;
      nb_q  <= {nb_i[W-2:0], 1'b0};
      q_q   <= {q_i[W-2:0], take};
    end
  end

  assign flags_o = flags_q;
  assign rem_o   = rem_q;
  assign den_o   = den_q;
  assign nb_o    = nb_q;
  assign q_o     = q_q;

endmodule

### src/plane_curve_curvature_core.sv
// order: operand stages, square-root row, divisor stages, divider row, output
// throughput: one item per cycle unless stalled; a row of DATA_WIDTH square-root cells and
// a row of DATA_WIDTH divider cells, each retiring one bit per item per cycle
// the whole row stalls only while a finished result waits at the output
// reset: asynchronous, active low; clears all valid flags and zero_tolerance
module plane_curve_curvature_core import ppc_pkg::*; #(
  parameter int unsigned DATA_WIDTH = ppc_pkg::DATA_WIDTH,
  parameter int unsigned FRAC_BITS  = ppc_pkg::FRAC_BITS
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  ppc_in_if.sink                in_s,
  ppc_out_if.source             out_m,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready
);

  localparam int unsigned W     = DATA_WIDTH;
  localparam int unsigned F     = FRAC_BITS;
  localparam int unsigned NUM_W = 2 * W + 2 * F;
  localparam int unsigned TOP_W = W + 2 * F;
  localparam int unsigned CMP_W = (3 * W > TOP_W) ? 3 * W : TOP_W;

  // ---------------------------------------------------------------
  // configuration register
  logic [TOL_W-1:0] tol_q;
  logic             cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr[2] == RegZeroTol);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tol_q <= '0;
    end else if (cfg_wr) begin
      tol_q <= pwdata[TOL_W-1:0];
    end
  end

  assign prdata = (paddr[2] == RegZeroTol) ? APB_DATA_W'(tol_q) : '0;

  // ---------------------------------------------------------------
  // row advance: everything moves unless the output holds an untaken result
  logic en;
  logic out_valid_q;

  assign en         = !out_valid_q || out_m.ready;
  assign in_s.ready = en;

  // ---------------------------------------------------------------
  // stage 1: magnitudes, signs and degenerate test
  logic         v1_q;
  logic [W-1:0] mdx_q, md2x_q, mdy_q, md2y_q;
  logic         ndx_q, nd2x_q, ndy_q, nd2y_q;
  logic         dg1_q;
  logic [W-1:0] mdx_d, mdy_d, tol_ext;

  always_comb begin
    mdx_d   = in_s.first_deriv_x[W-1] ? -in_s.first_deriv_x : in_s.first_deriv_x;
    mdy_d   = in_s.first_deriv_y[W-1] ? -in_s.first_deriv_y : in_s.first_deriv_y;
    tol_ext = W'(tol_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else if (en) begin
      v1_q <= in_s.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      mdx_q  <= mdx_d;
      mdy_q  <= mdy_d;
      md2x_q <= in_s.second_deriv_x[W-1] ? -in_s.second_deriv_x : in_s.second_deriv_x;
      md2y_q <= in_s.second_deriv_y[W-1] ? -in_s.second_deriv_y : in_s.second_deriv_y;
      ndx_q  <= in_s.first_deriv_x[W-1];
      nd2x_q <= in_s.second_deriv_x[W-1];
      ndy_q  <= in_s.first_deriv_y[W-1];
      nd2y_q <= in_s.second_deriv_y[W-1];
      dg1_q  <= (mdx_d <= tol_ext) && (mdy_d <= tol_ext);
    end
  end

  // ---------------------------------------------------------------
  // stage 2: the four products
  logic           v2_q, dg2_q, neg1_q, neg2_q;
  logic [2*W-1:0] p1_q, p2_q, pxx_q, pyy_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
    end else if (en) begin
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      p1_q   <= {{W{1'b0}}, mdx_q} * {{W{1'b0}}, md2y_q};
      p2_q   <= {{W{1'b0}}, mdy_q} * {{W{1'b0}}, md2x_q};
      pxx_q  <= {{W{1'b0}}, mdx_q} * {{W{1'b0}}, mdx_q};
      pyy_q  <= {{W{1'b0}}, mdy_q} * {{W{1'b0}}, mdy_q};
      neg1_q <= ndx_q ^ nd2y_q;
      neg2_q <= ~(ndy_q ^ nd2x_q);
      dg2_q  <= dg1_q;
    end
  end

  // ---------------------------------------------------------------
  // stage 3: signed numerator as sign and magnitude, squared norm
  ppc_flags_t     f3_q;
  logic [2*W-1:0] a3_q, n3_q;
  logic [2*W-1:0] a_d;
  logic           neg_d;

  always_comb begin
    if (neg1_q == neg2_q) begin
      a_d   = p1_q + p2_q;
      neg_d = neg1_q;
    end else if (p1_q >= p2_q) begin
      a_d   = p1_q - p2_q;
      neg_d = neg1_q;
    end else begin
      a_d   = p2_q - p1_q;
      neg_d = neg2_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      f3_q <= '0;
    end else if (en) begin
      f3_q <= '{valid: v2_q, neg: neg_d, degen: dg2_q, sat: 1'b0};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      a3_q <= a_d;
      n3_q <= pxx_q + pyy_q;
    end
  end

  // ---------------------------------------------------------------
  // square-root row, one root bit per cell
  ppc_flags_t     sq_f    [W+1];
  logic [W+1:0]   sq_rem  [W+1];
  logic [W-1:0]   sq_root [W+1];
  logic [2*W-1:0] sq_n    [W+1];
  logic [4*W-1:0] sq_side [W+1];

  assign sq_f[0]    = f3_q;
  assign sq_rem[0]  = '0;
  assign sq_root[0] = '0;
  assign sq_n[0]    = n3_q;
  assign sq_side[0] = {a3_q, n3_q};

  for (genvar i = 0; i < W; i++) begin : g_sqrt
    ppc_sqrt_cell #(
      .W      (W),
      .SIDE_W (4 * W)
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .flags_i (sq_f[i]),
      .rem_i   (sq_rem[i]),
      .root_i  (sq_root[i]),
      .n_i     (sq_n[i]),
      .side_i  (sq_side[i]),
      .flags_o (sq_f[i+1]),
      .rem_o   (sq_rem[i+1]),
      .root_o  (sq_root[i+1]),
      .n_o     (sq_n[i+1]),
      .side_o  (sq_side[i+1])
    );
  end

  // ---------------------------------------------------------------
  // stage 4: norm times root as two partial products
  ppc_flags_t     f4_q;
  logic [2*W-1:0] a4_q, plo_q, phi_q;
  logic [2*W-1:0] n_root;

  assign n_root = sq_side[W][2*W-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      f4_q <= '0;
    end else if (en) begin
      f4_q <= sq_f[W];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      a4_q  <= sq_side[W][4*W-1:2*W];
      plo_q <= {{W{1'b0}}, n_root[W-1:0]} * {{W{1'b0}}, sq_root[W]};
      phi_q <= {{W{1'b0}}, n_root[2*W-1:W]} * {{W{1'b0}}, sq_root[W]};
    end
  end

  // ---------------------------------------------------------------
  // stage 5: divisor
  ppc_flags_t     f5_q;
  logic [2*W-1:0] a5_q;
  logic [3*W-1:0] den5_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      f5_q <= '0;
    end else if (en) begin
      f5_q <= f4_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      a5_q   <= a4_q;
      den5_q <= {phi_q, {W{1'b0}}} + {{W{1'b0}}, plo_q};
    end
  end

  // ---------------------------------------------------------------
  // stage 6: overflow test on the upper dividend, divider start
  ppc_flags_t     f6_q;
  logic [3*W-1:0] rem6_q, den6_q;
  logic [W-1:0]   nb6_q;
  logic [NUM_W-1:0] num;
  logic [CMP_W-1:0] top_ext, den_ext;
  logic             sat_top;

  always_comb begin
    num     = {a5_q, {(2 * F){1'b0}}};
    top_ext = CMP_W'(num[NUM_W-1:W]);
    den_ext = CMP_W'(den5_q);
    sat_top = top_ext >= den_ext;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      f6_q <= '0;
    end else if (en) begin
      f6_q <= '{valid: f5_q.valid, neg: f5_q.neg, degen: f5_q.degen, sat: sat_top};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      rem6_q <= sat_top ? '0 : top_ext[3*W-1:0];
      den6_q <= den5_q;
      nb6_q  <= num[W-1:0];
    end
  end

  // ---------------------------------------------------------------
  // divider row, one quotient bit per cell
  ppc_flags_t     dv_f   [W+1];
  logic [3*W-1:0] dv_rem [W+1];
  logic [3*W-1:0] dv_den [W+1];
  logic [W-1:0]   dv_nb  [W+1];
  logic [W-1:0]   dv_q   [W+1];

  assign dv_f[0]   = f6_q;
  assign dv_rem[0] = rem6_q;
  assign dv_den[0] = den6_q;
  assign dv_nb[0]  = nb6_q;
  assign dv_q[0]   = '0;

  for (genvar i = 0; i < W; i++) begin : g_div
    ppc_div_cell #(
      .W (W)
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .flags_i (dv_f[i]),
      .rem_i   (dv_rem[i]),
      .den_i   (dv_den[i]),
      .nb_i    (dv_nb[i]),
      .q_i     (dv_q[i]),
      .flags_o (dv_f[i+1]),
      .rem_o   (dv_rem[i+1]),
      .den_o   (dv_den[i+1]),
      .nb_o    (dv_nb[i+1]),
      .q_o     (dv_q[i+1])
    );
  end

  // ---------------------------------------------------------------
  // output stage: clamp, apply sign, degenerate override
  ppc_flags_t   fo;
  logic [W-1:0] half, lim, qv, qs, res_d, max_pos;
  logic         sat_d;

  always_comb begin
    fo      = dv_f[W];
    qv      = dv_q[W];
    half    = {1'b1, {(W - 1){1'b0}}};
    max_pos = {1'b0, {(W - 1){1'b1}}};
    lim     = fo.neg ? half : max_pos;
    sat_d   = fo.sat || (qv > lim);
    qs      = sat_d ? lim : qv;
    res_d   = fo.neg ? -qs : qs;
    if (fo.degen) begin
      res_d = max_pos;
      sat_d = 1'b0;
    end
  end

  logic [W-1:0] curv_q;
  logic         degen_q, sat_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= fo.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      curv_q  <= res_d;
      degen_q <= fo.degen;
      sat_q   <= sat_d;
    end
  end

  assign out_m.valid      = out_valid_q;
  assign out_m.curvature  = curv_q;
  assign out_m.degenerate = degen_q;
  assign out_m.saturated  = sat_q;

  // ---------------------------------------------------------------
  // checks
  a_degen_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && degen_q |-> (curv_q == max_pos) && !sat_q)
    else $error("degenerate result is not the largest positive value");

  a_sat_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && sat_q |-> (curv_q == max_pos) || (curv_q == half))
    else $error("saturated result is not at a range limit");

  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !out_m.ready |=> $stable(f6_q) && $stable(f3_q))
    else $error("row advanced while the output was stalled");

endmodule

### tb/tb_plane_curve_curvature_core.sv
`timescale 1ns / 1ps

module tb_plane_curve_curvature_core;
  import ppc_pkg::*;

  localparam int unsigned DW = ppc_pkg::DATA_WIDTH;
  localparam int unsigned FB = ppc_pkg::FRAC_BITS;
  localparam int unsigned LATENCY = 2 * DW + 7;
  localparam int unsigned CYCLE_LIMIT = 2000000;
  localparam logic [APB_ADDR_W-1:0] AddrZeroTol = {RegZeroTol, 2'b00};
  localparam logic [APB_ADDR_W-1:0] AddrUnused = {1'b1, 2'b00};

  typedef struct {
    logic signed [DW-1:0] dx;
    logic signed [DW-1:0] d2x;
    logic signed [DW-1:0] dy;
    logic signed [DW-1:0] d2y;
  } point_t;

  typedef struct {
    logic signed [DW-1:0] curvature;
    logic degenerate;
    logic saturated;
  } curv_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [APB_ADDR_W-1:0] paddr = '0;
  logic [APB_DATA_W-1:0] pwdata = '0;
  logic [APB_DATA_W-1:0] prdata;
  logic pready;

  ppc_in_if #(.DW(DW)) pts_if ();
  ppc_out_if #(.DW(DW)) curv_if ();

  plane_curve_curvature_core uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_s   (pts_if),
    .out_m  (curv_if),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .pready (pready)
  );

  always #5 clk_i = ~clk_i;

  point_t pending_pts[$];
  curv_t expected_curv[$];
  logic [15:0] tol_shadow = '0;
  int unsigned err_count = 0;
  int unsigned cycle_count = 0;
  bit steady_flow = 1'b0;

  task automatic report(input string what);
    err_count++;
    $display("mismatch @%0t: %s", $realtime, what);
  endtask

  // exact curvature with truncated quotient and saturation
  function automatic curv_t curvature_of(input point_t p, input logic [15:0] tol);
    logic signed [127:0] sdx, sdy, sd2x, sd2y, area;
    logic [127:0] mdx, mdy, mag, nsq, cand, den, num, quo, lim;
    logic [127:0] root;
    curv_t r;
    sdx = p.dx;
    sdy = p.dy;
    sd2x = p.d2x;
    sd2y = p.d2y;
    mdx = (sdx < 0) ? -sdx : sdx;
    mdy = (sdy < 0) ? -sdy : sdy;
    r.degenerate = 1'b0;
    r.saturated = 1'b0;
    if (mdx <= tol && mdy <= tol) begin
      r.curvature = {1'b0, {(DW-1){1'b1}}};
      r.degenerate = 1'b1;
      return r;
    end
    area = sdx * sd2y - sdy * sd2x;
    mag = (area < 0) ? -area : area;
    nsq = mdx * mdx + mdy * mdy;
    root = '0;
    for (int b = DW - 1; b >= 0; b--) begin
      cand = root | (128'd1 << b);
      if (cand * cand <= nsq) root = cand;
    end
    den = nsq * root;
    num = mag << (2 * FB);
    quo = num / den;
    lim = (area < 0) ? (128'd1 << (DW - 1)) : ((128'd1 << (DW - 1)) - 1);
    if (quo > lim) begin
      quo = lim;
      r.saturated = 1'b1;
    end
    r.curvature = (area < 0) ? -quo[DW-1:0] : quo[DW-1:0];
    return r;
  endfunction

  // derivative value of random magnitude, extremes now and then
  function automatic logic signed [DW-1:0] rand_deriv();
    logic signed [DW-1:0] v;
    int unsigned k;
    case ($urandom_range(0, 9))
      0: v = {1'b1, {(DW-1){1'b0}}};
      1: v = {1'b0, {(DW-1){1'b1}}};
      2, 3: v = $urandom;
      default: begin
        k = $urandom_range(0, DW - 2);
        v = $urandom_range(0, (1 << k) - 1) | (1 << k);
        if ($urandom_range(0, 1)) v = -v;
        if ($urandom_range(0, 7) == 0) v = '0;
      end
    endcase
    return v;
  endfunction

  function automatic point_t mk_point(input logic signed [DW-1:0] a, b, c, d);
    point_t p;
    p.dx = a;
    p.d2x = b;
    p.dy = c;
    p.d2y = d;
    return p;
  endfunction

  function automatic int unsigned gap_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (steady_flow || r < 65) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // point driver
  int unsigned in_gap = 0;
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pts_if.valid <= 1'b0;
      pts_if.first_deriv_x <= '0;
      pts_if.second_deriv_x <= '0;
      pts_if.first_deriv_y <= '0;
      pts_if.second_deriv_y <= '0;
    end else if (!pts_if.valid || pts_if.ready) begin
      if (in_gap > 0) begin
        in_gap <= in_gap - 1;
        pts_if.valid <= 1'b0;
      end else if (pending_pts.size() > 0) begin
        point_t p;
        p = pending_pts.pop_front();
        pts_if.valid <= 1'b1;
        pts_if.first_deriv_x <= p.dx;
        pts_if.second_deriv_x <= p.d2x;
        pts_if.first_deriv_y <= p.dy;
        pts_if.second_deriv_y <= p.d2y;
        in_gap <= gap_len();
      end else begin
        pts_if.valid <= 1'b0;
      end
    end
  end

  // result side back pressure
  int unsigned out_gap = 0;
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      curv_if.ready <= 1'b0;
    end else if (out_gap > 0) begin
      out_gap <= out_gap - 1;
      curv_if.ready <= 1'b0;
    end else begin
      curv_if.ready <= 1'b1;
      out_gap <= gap_len();
    end
  end

  // predict on input transfer, check on output transfer
  always @(posedge clk_i) begin
    if (rst_ni) begin
      cycle_count <= cycle_count + 1;
      if (pts_if.valid && pts_if.ready)
        expected_curv.push_back(curvature_of(mk_point(pts_if.first_deriv_x,
          pts_if.second_deriv_x, pts_if.first_deriv_y, pts_if.second_deriv_y),
          tol_shadow));
      if (curv_if.valid && curv_if.ready) begin
        if (expected_curv.size() == 0) begin
          report("result transfer with nothing expected");
        end else begin
          curv_t e;
          e = expected_curv.pop_front();
          if (curv_if.curvature !== e.curvature)
            report($sformatf("curvature got %0d want %0d", curv_if.curvature,
              e.curvature));
          if (curv_if.degenerate !== e.degenerate)
            report($sformatf("degenerate got %b want %b", curv_if.degenerate,
              e.degenerate));
          if (curv_if.saturated !== e.saturated)
            report($sformatf("saturated got %b want %b", curv_if.saturated,
              e.saturated));
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (cycle_count > CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  task automatic apb_write(input logic [APB_ADDR_W-1:0] addr, input logic [31:0] data);
    @(posedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (addr == AddrZeroTol) tol_shadow = data[15:0];
  endtask

  task automatic drain();
    wait (pending_pts.size() == 0 && expected_curv.size() == 0 && !pts_if.valid);
    repeat (LATENCY + 10) @(posedge clk_i);
  endtask

  task automatic random_points(input int unsigned n);
    logic signed [DW-1:0] a, c;
    for (int i = 0; i < n; i++) begin
      a = rand_deriv();
      c = rand_deriv();
      // keep some first derivatives near the tolerance edge
      if ($urandom_range(0, 5) == 0) begin
        a = $signed({1'b0, tol_shadow}) + $signed($urandom_range(0, 2)) - 1;
        if ($urandom_range(0, 1)) a = -a;
        c = $urandom_range(0, tol_shadow + 1);
      end
      pending_pts.push_back(mk_point(a, rand_deriv(), c, rand_deriv()));
    end
  endtask

  localparam logic signed [DW-1:0] MaxV = {1'b0, {(DW-1){1'b1}}};
  localparam logic signed [DW-1:0] MinV = {1'b1, {(DW-1){1'b0}}};
  localparam logic signed [DW-1:0] One = 1 << FB;

  initial begin
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: extremes, degenerate, zero numerator, saturation both ways
    pending_pts.push_back(mk_point(0, 0, 0, 0));
    pending_pts.push_back(mk_point(1, 0, 0, 0));
    pending_pts.push_back(mk_point(One, 0, 0, One));
    pending_pts.push_back(mk_point(One, One, 0, 0));
    pending_pts.push_back(mk_point(0, One, One, 0));
    pending_pts.push_back(mk_point(1, 0, 0, MaxV));
    pending_pts.push_back(mk_point(1, 0, 0, MinV));
    pending_pts.push_back(mk_point(-1, MaxV, 0, MinV));
    pending_pts.push_back(mk_point(MinV, MinV, MinV, MinV));
    pending_pts.push_back(mk_point(MaxV, MaxV, MaxV, MaxV));
    pending_pts.push_back(mk_point(MinV, MaxV, MaxV, MinV));
    pending_pts.push_back(mk_point(MaxV, MinV, MinV, MaxV));
    pending_pts.push_back(mk_point(MinV, 0, 0, 1));
    pending_pts.push_back(mk_point(0, -1, -1, 0));
    pending_pts.push_back(mk_point(-One, One, One, One));
    pending_pts.push_back(mk_point(3 * One, -2 * One, 4 * One, 5 * One));
    pending_pts.push_back(mk_point(-1, -1, -1, -1));
    drain();

    // tolerance sweep, with a write to an unmapped register
    apb_write(AddrZeroTol, 32'd65535);
    apb_write(AddrUnused, 32'd7);
    paddr <= AddrZeroTol;
    @(posedge clk_i);
    if (prdata[15:0] !== 16'hFFFF) report("zero_tolerance read back");
    pending_pts.push_back(mk_point(16'hFFFF, 0, -32'sd65535, 0));
    pending_pts.push_back(mk_point(32'h10000, One, 0, One));
    pending_pts.push_back(mk_point(0, 0, -32'sh10000, One));
    random_points(250);
    drain();

    apb_write(AddrZeroTol, 32'd1);
    steady_flow = 1'b1;
    random_points(300);
    drain();

    steady_flow = 1'b0;
    apb_write(AddrZeroTol, $urandom_range(0, 65535));
    random_points(400);
    drain();

    apb_write(AddrZeroTol, 32'd0);
    random_points(580);
    drain();

    if (err_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
